[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fqsd_pkg.sv]
// shared types and codes of the key queue with sort and delete
package fqsd_pkg;

	localparam int KEY_W = 32;

	typedef logic signed [KEY_W-1:0] key_t;

	// command codes on the input beat
	typedef enum logic [2:0] {
		CMD_ENQUEUE   = 3'd0,
		CMD_DEQUEUE   = 3'd1,
		CMD_DUMP      = 3'd2,
		CMD_SORT_DESC = 3'd3,
		CMD_SORT_ASC  = 3'd4,
		CMD_DELETE    = 3'd5
	} cmd_t;

	// status codes on the result beat
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EMIT,
		S_DEQ,
		S_DUMP,
		S_SORT_FIRST,
		S_SORT_RUN,
		S_SORT_END,
		S_DEL_CMP,
		S_DEL_SHIFT
	} state_t;

	// operands and results of the shared comparator
	typedef struct packed {
		key_t a;
		key_t b;
	} cmp_req_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_res_t;

endpackage

[src/fqsd_cmp.sv]
// shared signed key comparator used by sort and delete
module fqsd_cmp
	import fqsd_pkg::*;
(
	input  cmp_req_t req,
	output cmp_res_t res
);

	// signed greater-than for the bubble step, equality for the delete search
	assign res.gt = ($signed(req.a) > $signed(req.b));
	assign res.eq = (req.a == req.b);

endmodule

[src/fqsd_store.sv]
// key store: one write port, one registered read port
module fqsd_store
	import fqsd_pkg::*;
#(
	parameter  int DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  key_t          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output key_t          rd_data
);

	key_t mem [DEPTH];
	key_t rd_data_q;

	// write and registered read; read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/fifo_queue_with_sort_and_delete_unit.sv]
// top level: bounded key queue with dump, bubble sort and delete by value
`include "assert_macros.svh"

// Bounded queue of up to DEPTH signed 32-bit keys in a circular store. One
// command beat is taken at a time; in_ready is low until its last result beat
// has been loaded into the output register. All work goes through the single
// store port pair (one write, one registered read) and one shared comparator.
// With n the number of live entries, enqueue and undefined commands go
// straight to their result beat, dequeue reads the head before its beat, dump
// sends one result beat per entry (one result beat per cycle without
// back-pressure), delete takes one compare or shift step per entry, and sort
// for n of two or more runs n - 1 bubble passes. Output back-pressure holds
// the sequencer in its emit and dump states. Store contents are not cleared
// at reset, so no clearing pass is needed.
module fifo_queue_with_sort_and_delete_unit
	import fqsd_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        command,
	input  logic signed [31:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [31:0] key_out,
	output logic [1:0]        status,
	output logic              last
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] DEPTH_C = PW'(DEPTH);
	localparam logic [PW-1:0] ONE_P   = PW'(1);
	localparam logic [PW-1:0] TWO_P   = PW'(2);

	// position in the queue to slot in the store
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic [AW-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, pos};
		if (sum >= DEPTH_C) begin
			sum = sum - DEPTH_C;
		end
		return sum[AW-1:0];
	endfunction

	state_t        state_q, state_d;
	logic [AW-1:0] head_q;
	logic [PW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] pass_q;
	logic          asc_q;
	key_t          carry_q;
	key_t          value_q;
	key_t          res_key_q;
	status_t       res_status_q;
	logic          out_valid_q;
	key_t          key_out_q;
	status_t       status_q;
	logic          last_q;

	cmd_t          cmd;
	logic          in_fire;
	logic          out_free;
	logic          full;
	logic          empty;
	logic [PW-1:0] last_pos;
	logic [PW-1:0] nxt1;
	logic [PW-1:0] nxt2;
	logic          idx_last;
	logic          nxt1_last;
	logic          pass_done;

	logic          rd_en;
	logic [AW-1:0] rd_pos;
	logic [AW-1:0] rd_addr;
	key_t          rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_pos;
	logic [AW-1:0] wr_addr;
	key_t          wr_data;

	logic          emit;
	key_t          emit_key;
	status_t       emit_status;
	logic          emit_last;

	cmp_req_t      cmp_req;
	cmp_res_t      cmp_res;

	// handshake and position arithmetic
	assign cmd       = cmd_t'(command);
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign last_pos  = count_q - ONE_P;
	assign nxt1      = {1'b0, idx_q} + ONE_P;
	assign nxt2      = {1'b0, idx_q} + TWO_P;
	assign idx_last  = ({1'b0, idx_q} == last_pos);
	assign nxt1_last = (nxt1 == last_pos);
	assign pass_done = (({1'b0, pass_q} + ONE_P) == last_pos);

	// comparator operands: search key in delete, carried key against next in sort
	always_comb begin
		if (state_q == S_DEL_CMP) begin
			cmp_req.a = rd_data;
			cmp_req.b = value_q;
		end else if (asc_q) begin
			cmp_req.a = carry_q;
			cmp_req.b = rd_data;
		end else begin
			cmp_req.a = rd_data;
			cmp_req.b = carry_q;
		end
	end

	fqsd_cmp u_cmp (
		.req (cmp_req),
		.res (cmp_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (cmd) inside
						CMD_ENQUEUE: state_d = S_EMIT;
						CMD_DEQUEUE: state_d = empty ? S_EMIT : S_DEQ;
						CMD_DUMP:    state_d = empty ? S_EMIT : S_DUMP;
						CMD_SORT_DESC, CMD_SORT_ASC: begin
							state_d = (count_q <= ONE_P) ? S_EMIT : S_SORT_FIRST;
						end
						CMD_DELETE:  state_d = empty ? S_EMIT : S_DEL_CMP;
						default:     state_d = S_EMIT;
					endcase
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DEQ:        state_d = S_EMIT;
			S_DUMP: begin
				if (out_free && idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_SORT_FIRST: state_d = S_SORT_RUN;
			S_SORT_RUN: begin
				if (nxt1_last) begin
					state_d = S_SORT_END;
				end
			end
			S_SORT_END:   state_d = pass_done ? S_EMIT : S_SORT_FIRST;
			S_DEL_CMP: begin
				if (cmp_res.eq && !idx_last) begin
					state_d = S_DEL_SHIFT;
				end else if (cmp_res.eq || idx_last) begin
					state_d = S_EMIT;
				end
			end
			S_DEL_SHIFT: begin
				if (nxt1_last) begin
					state_d = S_EMIT;
				end
			end
			default:      state_d = S_IDLE;
		endcase
	end

	// store port and result beat controls
	always_comb begin
		rd_en       = 1'b0;
		rd_pos      = '0;
		wr_en       = 1'b0;
		wr_pos      = '0;
		wr_data     = value;
		emit        = 1'b0;
		emit_key    = res_key_q;
		emit_status = res_status_q;
		emit_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (cmd == CMD_ENQUEUE) begin
						wr_en = !full;
						wr_pos = count_q[AW-1:0];
					end else begin
						rd_en = !empty;
					end
				end
			end
			S_EMIT: begin
				emit = out_free;
			end
			S_DEQ: begin
			end
			S_DUMP: begin
				emit = out_free;
				emit_key = rd_data;
				emit_status = ST_OK;
				emit_last = idx_last;
				if (out_free && !idx_last) begin
					rd_en = 1'b1;
					rd_pos = nxt1[AW-1:0];
				end
			end
			S_SORT_FIRST: begin
				rd_en = 1'b1;
				rd_pos = nxt1[AW-1:0];
			end
			S_SORT_RUN: begin
				wr_en = 1'b1;
				wr_pos = idx_q;
				wr_data = cmp_res.gt ? rd_data : carry_q;
				if (!nxt1_last) begin
					rd_en = 1'b1;
					rd_pos = nxt2[AW-1:0];
				end
			end
			S_SORT_END: begin
				wr_en = 1'b1;
				wr_pos = last_pos[AW-1:0];
				wr_data = carry_q;
				rd_en = !pass_done;
			end
			S_DEL_CMP: begin
				if (!idx_last) begin
					rd_en = 1'b1;
					rd_pos = nxt1[AW-1:0];
				end
			end
			S_DEL_SHIFT: begin
				wr_en = 1'b1;
				wr_pos = idx_q;
				wr_data = rd_data;
				if (!nxt1_last) begin
					rd_en = 1'b1;
					rd_pos = nxt2[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = slot_of(head_q, rd_pos);
	assign wr_addr = slot_of(head_q, wr_pos);

	fqsd_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			pass_q      <= '0;
			asc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						pass_q <= '0;
						asc_q <= (cmd == CMD_SORT_ASC);
						if (cmd == CMD_ENQUEUE && !full) begin
							count_q <= count_q + ONE_P;
						end
					end
				end
				S_DEQ: begin
					head_q <= slot_of(head_q, AW'(1));
					count_q <= count_q - ONE_P;
				end
				S_DUMP: begin
					if (out_free && !idx_last) begin
						idx_q <= nxt1[AW-1:0];
					end
				end
				S_SORT_RUN: begin
					if (!nxt1_last) begin
						idx_q <= nxt1[AW-1:0];
					end
				end
				S_SORT_END: begin
					pass_q <= pass_q + AW'(1);
					idx_q <= '0;
				end
				S_DEL_CMP: begin
					if (!cmp_res.eq && !idx_last) begin
						idx_q <= nxt1[AW-1:0];
					end
					if (cmp_res.eq && idx_last) begin
						count_q <= count_q - ONE_P;
					end
				end
				S_DEL_SHIFT: begin
					if (nxt1_last) begin
						count_q <= count_q - ONE_P;
					end else begin
						idx_q <= nxt1[AW-1:0];
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: search key, carried sort key, pending result, output beat
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					value_q <= value;
					res_key_q <= '0;
					if (cmd == CMD_ENQUEUE) begin
						res_status_q <= full ? ST_FULL : ST_OK;
					end else if (cmd == CMD_DEQUEUE || cmd == CMD_DUMP ||
						cmd == CMD_SORT_DESC || cmd == CMD_SORT_ASC ||
						cmd == CMD_DELETE) begin
						res_status_q <= empty ? ST_EMPTY : ST_OK;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_DEQ: begin
				res_key_q <= rd_data;
			end
			S_SORT_FIRST: begin
				carry_q <= rd_data;
			end
			S_SORT_RUN: begin
				if (!cmp_res.gt) begin
					carry_q <= rd_data;
				end
			end
			S_DEL_CMP: begin
				if (!cmp_res.eq && idx_last) begin
					res_status_q <= ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			key_out_q <= emit_key;
			status_q <= emit_status;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign key_out   = key_out_q;
	assign status    = status_q;
	assign last      = last_q;

	// checks on the sequencer and the store port
	`ASSERT_HOLDS(a_count_bound, count_q <= DEPTH_C, "entry count beyond depth")
	`ASSERT_NEXT(a_enq_count, in_fire && (command == CMD_ENQUEUE) && !full,
		count_q == $past(count_q) + ONE_P, "enqueue did not grow the queue")
	`ASSERT_IMPLIES(a_dump_more, out_valid && out_ready && !last,
		state_q == S_DUMP, "non-final beat taken outside a dump")
	`ASSERT_IMPLIES(a_port_clash, wr_en && rd_en, wr_addr != rd_addr,
		"store read and write hit the same slot")

endmodule

[tb/fifo_queue_with_sort_and_delete_unit_tb.sv]
// testbench for the key queue with dump, sort and delete by value
module fifo_queue_with_sort_and_delete_unit_tb;
	import fqsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 10;
	localparam int IDLE_PCT = 18;
	localparam int RANDOM_ITEMS = 430;
	localparam int CALM_FROM = 150;
	localparam int CALM_TO = 260;
	// extra clocks after the final drain, before the summary is printed
	localparam int SETTLE_CYCLES = 400;
	localparam int WATCHDOG_NS = 4_000_000;
	localparam int MAX_REPORTS = 10;

	// command codes the block does not define
	localparam logic [2:0] CMD_UNDEF_A = 3'd6;
	localparam logic [2:0] CMD_UNDEF_B = 3'd7;

	localparam key_t KEY_MAX = 32'sh7fff_ffff;
	localparam key_t KEY_MIN = 32'sh8000_0000;

	typedef struct packed {
		key_t    key;
		status_t st;
		logic    last;
	} reply_t;

	// one directed beat; where fixed is set the reply is typed in here
	typedef struct packed {
		logic [2:0] cmd;
		key_t       val;
		bit         fixed;
		key_t       key;
		status_t    st;
	} stim_row_t;

	localparam int N_ROWS = 24;
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{CMD_DEQUEUE,   32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{CMD_DUMP,      32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{CMD_SORT_DESC, 32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{CMD_SORT_ASC,  32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{CMD_DELETE,    32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{CMD_UNDEF_A,   32'sd0,     1'b1, 32'sd0, ST_OK},
		'{CMD_UNDEF_B,   -32'sd1,    1'b1, 32'sd0, ST_OK},
		'{CMD_ENQUEUE,   KEY_MAX,    1'b1, 32'sd0, ST_OK},
		'{CMD_ENQUEUE,   KEY_MIN,    1'b1, 32'sd0, ST_OK},
		'{CMD_ENQUEUE,   32'sd0,     1'b1, 32'sd0, ST_OK},
		'{CMD_ENQUEUE,   -32'sd1,    1'b1, 32'sd0, ST_OK},
		'{CMD_ENQUEUE,   32'sd5,     1'b1, 32'sd0, ST_OK},
		'{CMD_ENQUEUE,   32'sd5,     1'b1, 32'sd0, ST_OK},
		'{CMD_DUMP,      32'sd0,     1'b0, 32'sd0, ST_OK},
		'{CMD_SORT_ASC,  32'sd0,     1'b1, 32'sd0, ST_OK},
		'{CMD_DUMP,      32'sd0,     1'b0, 32'sd0, ST_OK},
		'{CMD_SORT_DESC, 32'sd0,     1'b1, 32'sd0, ST_OK},
		'{CMD_DUMP,      32'sd0,     1'b0, 32'sd0, ST_OK},
		'{CMD_DELETE,    32'sd5,     1'b1, 32'sd0, ST_OK},
		'{CMD_DELETE,    32'sd12345, 1'b1, 32'sd0, ST_NOTFOUND},
		'{CMD_DEQUEUE,   32'sd0,     1'b0, 32'sd0, ST_OK},
		'{CMD_DELETE,    KEY_MIN,    1'b1, 32'sd0, ST_OK},
		'{CMD_DUMP,      32'sd0,     1'b0, 32'sd0, ST_OK},
		'{CMD_UNDEF_A,   KEY_MAX,    1'b1, 32'sd0, ST_OK}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] command = '0;
	key_t       value = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	key_t       key_out;
	logic [1:0] status;
	logic       last;

	// mirror of the live keys, head first, and the replies still to arrive
	key_t   live_keys[$];
	reply_t fresh_replies[$];
	reply_t awaited_replies[$];

	bit calm = 1'b0;
	int mismatches = 0;
	int replies_checked = 0;
	int random_sent = 0;
	int full_drops = 0;
	int misses = 0;
	int cmd_seen[8];

	fifo_queue_with_sort_and_delete_unit #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_out(key_out),
		.status(status),
		.last(last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// replies for one command beat, applied to the mirrored queue
	function automatic void compute_replies(input logic [2:0] c, input key_t v);
		key_t tmp;
		int hit;
		int n;
		fresh_replies.delete();
		n = live_keys.size();
		case (c)
			CMD_ENQUEUE: begin
				if (n >= DEPTH) begin
					fresh_replies.push_back(reply_t'{'0, ST_FULL, 1'b1});
					full_drops++;
				end else begin
					live_keys.push_back(v);
					fresh_replies.push_back(reply_t'{'0, ST_OK, 1'b1});
				end
			end
			CMD_DEQUEUE: begin
				if (n == 0)
					fresh_replies.push_back(reply_t'{'0, ST_EMPTY, 1'b1});
				else
					fresh_replies.push_back(reply_t'{live_keys.pop_front(), ST_OK, 1'b1});
			end
			CMD_DUMP: begin
				if (n == 0)
					fresh_replies.push_back(reply_t'{'0, ST_EMPTY, 1'b1});
				else
					foreach (live_keys[i])
						fresh_replies.push_back(reply_t'{live_keys[i], ST_OK, i == n - 1});
			end
			CMD_SORT_DESC, CMD_SORT_ASC: begin
				if (n == 0) begin
					fresh_replies.push_back(reply_t'{'0, ST_EMPTY, 1'b1});
				end else begin
					// bubble passes, swapping only on strict order so equal keys stay put
					for (int p = 0; p < n; p++)
						for (int i = 0; i + 1 < n; i++)
							if (c == CMD_SORT_ASC ? live_keys[i] > live_keys[i+1]
									: live_keys[i+1] > live_keys[i]) begin
								tmp = live_keys[i];
								live_keys[i] = live_keys[i+1];
								live_keys[i+1] = tmp;
							end
					fresh_replies.push_back(reply_t'{'0, ST_OK, 1'b1});
				end
			end
			CMD_DELETE: begin
				hit = -1;
				for (int i = 0; i < n && hit < 0; i++)
					if (live_keys[i] == v)
						hit = i;
				if (n == 0) begin
					fresh_replies.push_back(reply_t'{'0, ST_EMPTY, 1'b1});
				end else if (hit < 0) begin
					fresh_replies.push_back(reply_t'{'0, ST_NOTFOUND, 1'b1});
					misses++;
				end else begin
					live_keys.delete(hit);
					fresh_replies.push_back(reply_t'{'0, ST_OK, 1'b1});
				end
			end
			default:
				fresh_replies.push_back(reply_t'{'0, ST_OK, 1'b1});
		endcase
	endfunction

	// drive one command beat from the falling edge and record its replies
	task automatic send_command(input logic [2:0] c, input key_t v, input bit fixed,
			input reply_t want);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = c;
		value = v;
		do @(posedge clk); while (!in_ready);
		compute_replies(c, v);
		if (fixed)
			awaited_replies.push_back(want);
		else
			foreach (fresh_replies[i])
				awaited_replies.push_back(fresh_replies[i]);
		cmd_seen[c]++;
	endtask

	// hold the sender off until every awaited reply is in
	task automatic drain_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// keys: extremes, a narrow band that gives duplicates, or anything
	function automatic key_t pick_key();
		int sel;
		sel = $urandom_range(7);
		case (sel)
			0: return KEY_MIN;
			1: return KEY_MAX;
			2, 3: return key_t'($urandom_range(16)) - 32'sd8;
			default: return key_t'($urandom);
		endcase
	endfunction

	// delete mostly keys that are present, sometimes ones that are not
	function automatic key_t pick_victim();
		if (live_keys.size() != 0 && $urandom_range(9) < 7)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		return pick_key();
	endfunction

	task automatic run_random();
		int kind;
		int len;
		int sel;
		logic [2:0] c;
		key_t v;
		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(3);
			len = (kind == 3) ? $urandom_range(3, 6) : $urandom_range(4, 20);
			for (int k = 0; k < len; k++) begin
				calm = random_sent >= CALM_FROM && random_sent < CALM_TO;
				case (kind)
					0: c = CMD_ENQUEUE;
					1: c = CMD_DEQUEUE;
					2: begin
						sel = $urandom_range(9);
						case (sel)
							0, 1, 2: c = CMD_ENQUEUE;
							3, 4: c = CMD_DEQUEUE;
							5: c = CMD_DUMP;
							6: c = CMD_SORT_DESC;
							7: c = CMD_SORT_ASC;
							8: c = CMD_DELETE;
							default: c = $urandom_range(1) ? CMD_UNDEF_A : CMD_UNDEF_B;
						endcase
					end
					default: begin
						sel = $urandom_range(3);
						case (sel)
							0: c = CMD_DUMP;
							1: c = CMD_SORT_DESC;
							2: c = CMD_SORT_ASC;
							default: c = CMD_DELETE;
						endcase
					end
				endcase
				v = (c == CMD_DELETE) ? pick_victim() : pick_key();
				send_command(c, v, 1'b0, '0);
				random_sent++;
			end
			if ($urandom_range(9) < 2)
				drain_replies();
		end
		calm = 1'b0;
	endtask

	// receiver stalls at random outside the calm stretch
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// compare each result beat with the oldest awaited reply
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			replies_checked++;
			if (awaited_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result beat: key %0d status %0d last %0b",
						$realtime, key_out, status, last);
			end else begin
				want = awaited_replies.pop_front();
				if (key_out !== want.key || status !== want.st || last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t result mismatch: expected key %0d status %0d last %0b, got key %0d status %0d last %0b",
							$realtime, want.key, want.st, want.last, key_out, status, last);
				end
			end
		end
	end

	initial begin
		#(WATCHDOG_NS);
		$display("timeout with %0d replies outstanding", awaited_replies.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (DIRECTED_ROWS[r])
			send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].val, DIRECTED_ROWS[r].fixed,
				reply_t'{DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].st, 1'b1});
		drain_replies();

		run_random();
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d command beats (enq %0d, deq %0d, dump %0d, sort %0d, del %0d, undef %0d)",
			N_ROWS + random_sent, cmd_seen[CMD_ENQUEUE], cmd_seen[CMD_DEQUEUE],
			cmd_seen[CMD_DUMP], cmd_seen[CMD_SORT_DESC] + cmd_seen[CMD_SORT_ASC],
			cmd_seen[CMD_DELETE], cmd_seen[CMD_UNDEF_A] + cmd_seen[CMD_UNDEF_B]);
		$display("%0d result beats checked, %0d dropped on full, %0d deletes missed, %0d mismatches",
			replies_checked, full_drops, misses, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/fqsd_pkg.sv
src/fqsd_cmp.sv
src/fqsd_store.sv
src/fifo_queue_with_sort_and_delete_unit.sv
tb/fifo_queue_with_sort_and_delete_unit_tb.sv
